// ----- hw/rtl/cssp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cssp_pkg: shared types and constants for the support point core
// Item structs, shape codes and fixed point constants.
// ----------------------------------------------------------------------------
package cssp_pkg;

  localparam int unsigned MaxPoints = 256;
  localparam int unsigned IdxBits   = 8;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned FracBits  = CoordBits - 4;
  localparam int unsigned DotBits   = 2 * CoordBits + 2;
  localparam int unsigned SqBits    = 2 * CoordBits + 2;
  localparam int unsigned RootBits  = SqBits / 2;
  localparam int unsigned NumBits   = CoordBits + FracBits + 2;

  localparam logic signed [CoordBits-1:0] OneVal = CoordBits'(1 << FracBits);
  localparam logic signed [CoordBits-1:0] NegOne = -OneVal;

  localparam logic [2:0] ShapeCube     = 3'd0;
  localparam logic [2:0] ShapeSphere   = 3'd1;
  localparam logic [2:0] ShapeCapsule  = 3'd2;
  localparam logic [2:0] ShapeMesh     = 3'd3;
  localparam logic [2:0] ShapeTriangle = 3'd4;

  localparam logic       OpWrite = 1'b0;
  localparam logic       OpQuery = 1'b1;

  localparam logic       RegShapeKind  = 1'b0;
  localparam logic       RegPointCount = 1'b1;

  typedef struct packed {
    logic                        op;
    logic [IdxBits-1:0]          point_index;
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
    logic signed [CoordBits-1:0] point_z;
    logic signed [CoordBits-1:0] dir_x;
    logic signed [CoordBits-1:0] dir_y;
    logic signed [CoordBits-1:0] dir_z;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] support_x;
    logic signed [CoordBits-1:0] support_y;
    logic signed [CoordBits-1:0] support_z;
    logic [IdxBits-1:0]          chosen_index;
    logic                        no_points;
  } out_item_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic signed [CoordBits-1:0] z;
  } vec_t;

endpackage

// ----- hw/rtl/cssp_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cssp_divider: restoring divider, one quotient bit per cycle
// Computes num / den for unsigned operands; shared by all normalize steps.
// ----------------------------------------------------------------------------
module cssp_divider import cssp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NumBits-1:0]  num_i,
  input  logic [RootBits:0]   den_i,
  output logic                done_o,
  output logic [NumBits-1:0]  quot_o
);

  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0]  quot_q, quot_d;
  logic [RootBits+1:0] rem_q, rem_d;
  logic [RootBits:0]   den_q, den_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [RootBits+1:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[RootBits:0], quot_q[NumBits-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntBits'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- hw/rtl/convex_shape_support_point_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_shape_support_point_core: GJK support mapping, Q4.12 fixed point
// Point writes fill a 256-entry store; queries return the support point.
// ----------------------------------------------------------------------------
// Path per query: cube, empty mesh and unused kinds go straight to the output;
//   triangle and mesh scan the store (one store read and three shared multiplies
//   per point); sphere/capsule sum the squares, take a bit-serial root, run three
//   divides and then output, or go straight to output for a zero direction.
// Flow: writes are taken one per cycle while idle with no result held; a query
//   holds ready low until its result is taken.
// Reset: control state and the config registers clear; store is not cleared.

module convex_shape_support_point_core import cssp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o,
  input  logic      cfg_we_i,
  input  logic      cfg_index_i,
  input  logic [8:0] cfg_data_i
);

  typedef enum logic [3:0] {
    StIdle, StRead, StMac, StSqr, StRoot, StDivStart, StDivWait, StOut
  } state_e;

  state_e state_q;

  logic [2:0] shape_q;
  logic [8:0] count_q;

  // point store: one write or one read port a cycle, registered read
  vec_t       store_mem [MaxPoints];
  vec_t       rd_q;
  logic [IdxBits-1:0] rd_addr;
  logic       rd_en;

  vec_t       dir_q;
  logic [8:0] idx_q;      // next slot to read
  logic [8:0] last_q;     // scan limit
  logic [IdxBits-1:0] cur_q;  // slot whose data is in rd_q
  logic       rd_vld_q;
  logic signed [DotBits-1:0] best_q;
  logic [IdxBits-1:0]        best_idx_q;
  vec_t       best_pt_q;
  logic       have_q;

  // shared multiply-accumulate: one product a cycle
  logic signed [CoordBits-1:0] ma, mb;
  logic signed [2*CoordBits-1:0] prod;
  logic signed [DotBits-1:0] acc_q;
  logic [1:0] term_q;

  // root and divider
  logic [SqBits-1:0]   rs_q, rr_q, rbit_q;
  logic [1:0]          comp_q;
  logic                div_start;
  logic [NumBits-1:0]  div_num, div_quot;
  logic                div_done;
  logic signed [CoordBits-1:0] nres [3];
  logic                dir_neg;
  logic [CoordBits-1:0] mag;

  out_item_t out_q;
  out_item_t out_init;   // result fields known at accept time
  logic      out_vld_q;
  logic      in_fire;

  assign in_ready_o  = (state_q == StIdle) && !out_vld_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  always_comb begin
    out_init = '0;
    if (shape_q == ShapeCube) begin
      out_init.support_x = (in_item_i.dir_x > 0) ? OneVal : NegOne;
      out_init.support_y = (in_item_i.dir_y > 0) ? OneVal : NegOne;
      out_init.support_z = (in_item_i.dir_z > 0) ? OneVal : NegOne;
    end
    if (shape_q == ShapeMesh && count_q == '0) out_init.no_points = 1'b1;
  end

  always_comb begin
    unique case (term_q)
      2'd0:    begin ma = rd_q.x; mb = dir_q.x; end
      2'd1:    begin ma = rd_q.y; mb = dir_q.y; end
      default: begin ma = rd_q.z; mb = dir_q.z; end
    endcase
    if (state_q == StSqr) begin
      unique case (term_q)
        2'd0:    begin ma = dir_q.x; mb = dir_q.x; end
        2'd1:    begin ma = dir_q.y; mb = dir_q.y; end
        default: begin ma = dir_q.z; mb = dir_q.z; end
      endcase
    end
  end
  assign prod = ma * mb;

  assign rd_en   = (state_q == StRead) || ((state_q == StMac) && term_q == 2'd2 && idx_q < last_q);
  assign rd_addr = idx_q[IdxBits-1:0];

  always_comb begin
    unique case (comp_q)
      2'd0:    dir_neg = dir_q.x[CoordBits-1];
      2'd1:    dir_neg = dir_q.y[CoordBits-1];
      default: dir_neg = dir_q.z[CoordBits-1];
    endcase
    unique case (comp_q)
      2'd0:    mag = dir_neg ? -dir_q.x : dir_q.x;
      2'd1:    mag = dir_neg ? -dir_q.y : dir_q.y;
      default: mag = dir_neg ? -dir_q.z : dir_q.z;
    endcase
    // 2*|d|*ONE + L over 2*L
    div_num = NumBits'({mag, 1'b0, {FracBits{1'b0}}}) + NumBits'(rr_q);
  end
  assign div_start = (state_q == StDivStart);

  cssp_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   ({rr_q[RootBits-1:0], 1'b0}),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire && in_item_i.op == OpWrite) begin
      store_mem[in_item_i.point_index] <= '{in_item_i.point_x, in_item_i.point_y,
                                            in_item_i.point_z};
    end
    if (rd_en) rd_q <= store_mem[rd_addr];
  end

  logic signed [DotBits-1:0] acc_n;
  logic [SqBits-1:0] rsum;
  assign acc_n = (term_q == 2'd0 ? '0 : acc_q) + DotBits'(prod);
  assign rsum  = rr_q + rbit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      shape_q   <= ShapeCube;
      count_q   <= '0;
      out_vld_q <= 1'b0;
      term_q    <= '0;
      idx_q     <= '0;
      last_q    <= '0;
      have_q    <= 1'b0;
      comp_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == RegShapeKind) shape_q <= cfg_data_i[2:0];
        else                             count_q <= cfg_data_i;
      end
      if (out_vld_q && out_ready_i) out_vld_q <= 1'b0;
      unique case (state_q)
        StIdle: if (in_fire && in_item_i.op == OpQuery) begin
          dir_q  <= '{in_item_i.dir_x, in_item_i.dir_y, in_item_i.dir_z};
          out_q  <= out_init;
          idx_q  <= '0;
          term_q <= '0;
          have_q <= 1'b0;
          comp_q <= '0;
          unique case (shape_q)
            ShapeCube: state_q <= StOut;
            ShapeSphere, ShapeCapsule: state_q <= StSqr;
            ShapeMesh: begin
              // counts past the store size scan the whole store
              last_q <= (count_q > 9'(MaxPoints)) ? 9'(MaxPoints) : count_q;
              if (count_q == '0) state_q <= StOut;
              else state_q <= StRead;
            end
            ShapeTriangle: begin last_q <= 9'd3; state_q <= StRead; end
            default: state_q <= StOut;
          endcase
        end
        StRead: begin
          idx_q   <= idx_q + 1'b1;
          cur_q   <= idx_q[IdxBits-1:0];
          state_q <= StMac;
        end
        StMac: begin
          acc_q  <= acc_n;
          term_q <= (term_q == 2'd2) ? 2'd0 : term_q + 1'b1;
          if (term_q == 2'd2) begin
            // mesh ties keep the earlier slot, triangle ties take the later one
            if (!have_q || acc_n > best_q ||
                (shape_q == ShapeTriangle && acc_n == best_q)) begin
              best_q     <= acc_n;
              best_idx_q <= cur_q;
              best_pt_q  <= rd_q;
            end
            have_q <= 1'b1;
            if (idx_q < last_q) begin
              idx_q <= idx_q + 1'b1;
              cur_q <= idx_q[IdxBits-1:0];
            end else state_q <= StOut;
          end
        end
        StSqr: begin
          acc_q  <= acc_n;
          term_q <= (term_q == 2'd2) ? 2'd0 : term_q + 1'b1;
          if (term_q == 2'd2) begin
            rs_q   <= SqBits'(acc_n);
            rr_q   <= '0;
            rbit_q <= SqBits'(1) << (SqBits - 2);
            if (acc_n == '0) state_q <= StOut;
            else state_q <= StRoot;
          end
        end
        StRoot: begin
          // bit-serial integer square root
          if (rbit_q == '0) state_q <= StDivStart;
          else begin
            if (rs_q >= rsum) begin
              rs_q <= rs_q - rsum;
              rr_q <= (rr_q >> 1) + rbit_q;
            end else rr_q <= rr_q >> 1;
            rbit_q <= rbit_q >> 2;
          end
        end
        StDivStart: state_q <= StDivWait;
        StDivWait: if (div_done) begin
          nres[comp_q] <= dir_neg ? -CoordBits'(div_quot) : CoordBits'(div_quot);
          if (comp_q == 2'd2) state_q <= StOut;
          else begin
            comp_q  <= comp_q + 1'b1;
            state_q <= StDivStart;
          end
        end
        StOut: begin
          if (shape_q == ShapeMesh || shape_q == ShapeTriangle) begin
            if (have_q) begin
              out_q.support_x    <= best_pt_q.x;
              out_q.support_y    <= best_pt_q.y;
              out_q.support_z    <= best_pt_q.z;
              out_q.chosen_index <= best_idx_q;
            end
          end else if (shape_q == ShapeSphere || shape_q == ShapeCapsule) begin
            if (comp_q == 2'd2) begin
              out_q.support_x <= nres[0];
              out_q.support_z <= nres[2];
            end
            if (shape_q == ShapeCapsule)
              out_q.support_y <= (comp_q == 2'd2 ? nres[1] : '0) +
                                 ((dir_q.y > 0) ? OneVal : NegOne);
            else if (comp_q == 2'd2)
              out_q.support_y <= nres[1];
          end
          out_vld_q <= 1'b1;
          state_q   <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // read strobe delayed to line up with rd_q
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_vld_q <= 1'b0;
    else         rd_vld_q <= rd_en;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !in_ready_o) else $error("ready while item held");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMac && term_q == 2'd0) |-> rd_vld_q)
    else $error("mac without read");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRoot) |=> (state_q == StRoot || state_q == StDivStart))
    else $error("root left early");

endmodule
